>>> rtl/core/ptsps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptsps_pkg
// Shared types and codes of the pan/tilt scan pattern sequencer.
// ----------------------------------------------------------------------------
package ptsps_pkg;

    localparam int MAX_AREAS_DEF    = 8;
    localparam int MAX_SEQUENCE_DEF = 8;

    // wide enough for any table index and for depths up to 127
    localparam int IDX_W = 7;

    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_STOP     = 3'd2;
    localparam logic [2:0] MODE_LOAD_AREA = 3'd3;
    localparam logic [2:0] MODE_LOAD_SEQ = 3'd4;

    localparam logic [1:0] PAT_RECT  = 2'd0;
    localparam logic [1:0] PAT_ZIG_H = 2'd1;
    localparam logic [1:0] PAT_ZIG_V = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PREVIEW = 2'd1;
    localparam logic [1:0] EV_ATTACK  = 2'd2;
    localparam logic [1:0] EV_UNKNOWN = 2'd3;

    localparam logic [1:0] CFG_TOLERANCE   = 2'd0;
    localparam logic [1:0] CFG_STEP_SIZE   = 2'd1;
    localparam logic [1:0] CFG_TOTAL_AREAS = 2'd2;

    typedef struct packed {
        logic [7:0] max_y;
        logic [7:0] min_y;
        logic [7:0] max_x;
        logic [7:0] min_x;
    } t_bounds;

    typedef struct packed {
        logic [7:0] target_x;
        logic [7:0] target_y;
        logic       running;
        logic [1:0] kind;
        t_bounds    bounds;
        logic [8:0] step;
        logic [3:0] phase;
    } t_state;

    typedef struct packed {
        logic       wr_area;
        logic       wr_seq;
        logic       flush;
        logic [2:0] area_idx;
        logic [2:0] slot_idx;
        t_bounds    bounds;
    } t_mem_req;

    typedef struct packed {
        logic    valid;
        t_bounds bounds;
    } t_pf;

endpackage : ptsps_pkg
`default_nettype wire

>>> rtl/core/pan_tilt_scan_pattern_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pan_tilt_scan_pattern_sequencer_top
// Pan/tilt servo target sequencer: rectangle preview and zigzag raster scans
// over a list of areas held in on-chip tables.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   mode, positions, pattern,
//                                                  bounds, indexes, home
//   out       output     o_out_valid / i_out_ready targets, event, busy
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One word per cycle unless input is held off; each accepted input word gives
// one registered result word. After a start, a stop, a table load, any other
// non-tick word or an area change, the next area's bounds are fetched from
// the tables by a sequence read, a table read and a capture; a running zigzag
// accepts no word until that fetch is done. Reset is synchronous; it clears
// control state, sets the register file to defaults; tables stay unwritten.
// A full output register holds off input unless it is taken in the same cycle.
// ----------------------------------------------------------------------------
module pan_tilt_scan_pattern_sequencer_top
    import ptsps_pkg::*;
#(
    parameter int MAX_AREAS    = MAX_AREAS_DEF,
    parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_pos_x,
    input  wire logic [7:0] i_pos_y,
    input  wire logic [1:0] i_pattern,
    input  wire logic [7:0] i_min_x,
    input  wire logic [7:0] i_max_x,
    input  wire logic [7:0] i_min_y,
    input  wire logic [7:0] i_max_y,
    input  wire logic [2:0] i_area_index,
    input  wire logic [2:0] i_slot_index,
    input  wire logic [7:0] i_home_x,
    input  wire logic [7:0] i_home_y,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_target_x,
    output logic [7:0]      o_target_y,
    output logic [1:0]      o_event_code,
    output logic            o_busy_res,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    t_state     r_st;
    t_state     n_st;
    logic [7:0] r_tolerance;
    logic [7:0] r_step_size;
    logic [3:0] r_total_areas;
    logic       r_out_valid;
    logic [7:0] r_target_x;
    logic [7:0] r_target_y;
    logic [1:0] r_event;
    logic       r_busy;

    t_bounds    w_bounds;
    t_mem_req   w_req;
    t_pf        w_pf;
    logic [1:0] w_event;
    logic       w_area_done;
    logic       w_stall;
    logic       w_in_acc;

    assign w_bounds = '{max_y: i_max_y, min_y: i_min_y, max_x: i_max_x, min_x: i_min_x};

    // a running zigzag may chain to the next area on any tick
    assign w_stall    = r_st.running && ((r_st.kind == PAT_ZIG_H) || (r_st.kind == PAT_ZIG_V))
                        && !w_pf.valid;
    assign o_in_ready = (!r_out_valid || i_out_ready) && !w_stall;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_req.wr_area  = w_in_acc && (i_mode == MODE_LOAD_AREA);
    assign w_req.wr_seq   = w_in_acc && (i_mode == MODE_LOAD_SEQ);
    assign w_req.flush    = w_in_acc && ((i_mode != MODE_TICK) || w_area_done);
    assign w_req.area_idx = i_area_index;
    assign w_req.slot_idx = i_slot_index;
    assign w_req.bounds   = w_bounds;

    ptsps_area_mem #(
        .MAX_AREAS    (MAX_AREAS),
        .MAX_SEQUENCE (MAX_SEQUENCE)
    ) u_area_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_phase (r_st.phase),
        .o_pf    (w_pf)
    );

    ptsps_step u_step (
        .i_state       (r_st),
        .i_mode        (i_mode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pattern     (i_pattern),
        .i_bounds      (w_bounds),
        .i_home_x      (i_home_x),
        .i_home_y      (i_home_y),
        .i_tolerance   (r_tolerance),
        .i_step_size   (r_step_size),
        .i_total_areas (r_total_areas),
        .i_next_bounds (w_pf.bounds),
        .o_state       (n_st),
        .o_event       (w_event),
        .o_area_done   (w_area_done)
    );

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance   <= 8'd2;
            r_step_size   <= 8'd10;
            r_total_areas <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOLERANCE:   r_tolerance   <= i_cfg_data;
                CFG_STEP_SIZE:   r_step_size   <= i_cfg_data;
                CFG_TOTAL_AREAS: r_total_areas <= i_cfg_data[3:0];
                default: begin
                    r_tolerance <= r_tolerance;
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_in_acc) begin
            r_st <= n_st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_target_x <= n_st.target_x;
            r_target_y <= n_st.target_y;
            r_event    <= w_event;
            r_busy     <= n_st.running;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_target_x   = r_target_x;
    assign o_target_y   = r_target_y;
    assign o_event_code = r_event;
    assign o_busy_res   = r_busy;

endmodule : pan_tilt_scan_pattern_sequencer_top
`default_nettype wire

>>> rtl/core/ptsps_area_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptsps_area_mem
// Area bounds table and area visit sequence, with a prefetch of the bounds
// of the area that follows the current phase.
// ----------------------------------------------------------------------------
module ptsps_area_mem
    import ptsps_pkg::*;
#(
    parameter int MAX_AREAS    = MAX_AREAS_DEF,
    parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_mem_req   i_req,
    input  wire logic [3:0] i_phase,
    output t_pf             o_pf
);

    localparam int TA_W = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int SA_W = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;

    typedef enum logic [1:0] {PF_SEQ, PF_TAB, PF_CAP, PF_VALID} t_pf_st;

    t_bounds    r_tab_mem [MAX_AREAS];
    logic [2:0] r_seq_mem [MAX_SEQUENCE];

    t_pf_st     r_pf_st;
    logic       r_seq_ok;
    logic       r_tab_ok;
    logic [2:0] r_seq_q;
    t_bounds    r_tab_q;
    t_bounds    r_nb;

    logic [3:0]       w_next_phase;
    logic [IDX_W-1:0] w_np_wide;
    logic [IDX_W-1:0] w_area_wide;
    logic [IDX_W-1:0] w_widx_area;
    logic [IDX_W-1:0] w_widx_slot;
    logic [2:0]       w_area;
    logic             w_np_ok;
    logic             w_area_ok;

    assign w_next_phase = i_phase + 4'd1;
    assign w_np_wide    = {{(IDX_W-4){1'b0}}, w_next_phase};
    assign w_np_ok      = w_np_wide < IDX_W'(MAX_SEQUENCE);
    assign w_area       = r_seq_ok ? r_seq_q : 3'd0;
    assign w_area_wide  = {{(IDX_W-3){1'b0}}, w_area};
    assign w_area_ok    = w_area_wide < IDX_W'(MAX_AREAS);
    assign w_widx_area  = {{(IDX_W-3){1'b0}}, i_req.area_idx};
    assign w_widx_slot  = {{(IDX_W-3){1'b0}}, i_req.slot_idx};

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_req.wr_area && (w_widx_area < IDX_W'(MAX_AREAS))) begin
            r_tab_mem[w_widx_area[TA_W-1:0]] <= i_req.bounds;
        end
        r_tab_q <= r_tab_mem[w_area_wide[TA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_seq && (w_widx_slot < IDX_W'(MAX_SEQUENCE))) begin
            r_seq_mem[w_widx_slot[SA_W-1:0]] <= i_req.area_idx;
        end
        r_seq_q <= r_seq_mem[w_np_wide[SA_W-1:0]];
    end

    // prefetch sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf_st  <= PF_SEQ;
            r_seq_ok <= 1'b0;
            r_tab_ok <= 1'b0;
        end else if (i_req.flush) begin
            r_pf_st <= PF_SEQ;
        end else begin
            case (r_pf_st)
                PF_SEQ: begin
                    r_seq_ok <= w_np_ok;
                    r_pf_st  <= PF_TAB;
                end
                PF_TAB: begin
                    r_tab_ok <= w_area_ok;
                    r_pf_st  <= PF_CAP;
                end
                PF_CAP: begin
                    r_nb    <= r_tab_ok ? r_tab_q : t_bounds'('0);
                    r_pf_st <= PF_VALID;
                end
                default: begin
                    r_pf_st <= PF_VALID;
                end
            endcase
        end
    end

    assign o_pf.valid  = (r_pf_st == PF_VALID);
    assign o_pf.bounds = r_nb;

endmodule : ptsps_area_mem
`default_nettype wire

>>> rtl/core/ptsps_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptsps_step
// Next state and event for one command word: arrival test, rectangle corners,
// zigzag line stepping and area chaining.
// ----------------------------------------------------------------------------
module ptsps_step
    import ptsps_pkg::*;
(
    input  wire t_state     i_state,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_pos_x,
    input  wire logic [7:0] i_pos_y,
    input  wire logic [1:0] i_pattern,
    input  wire t_bounds    i_bounds,
    input  wire logic [7:0] i_home_x,
    input  wire logic [7:0] i_home_y,
    input  wire logic [7:0] i_tolerance,
    input  wire logic [7:0] i_step_size,
    input  wire logic [3:0] i_total_areas,
    input  wire t_bounds    i_next_bounds,
    output t_state          o_state,
    output logic [1:0]      o_event,
    output logic            o_area_done
);

    logic [7:0]  w_dx;
    logic [7:0]  w_dy;
    logic        w_arrived;
    logic        w_even;
    logic [16:0] w_prod;
    logic [7:0]  w_near;
    logic [7:0]  w_far;
    logic [17:0] w_line;
    logic        w_past;
    logic [3:0]  w_phase_n;

    assign w_dx = (i_pos_x > i_state.target_x) ? i_pos_x - i_state.target_x
                                               : i_state.target_x - i_pos_x;
    assign w_dy = (i_pos_y > i_state.target_y) ? i_pos_y - i_state.target_y
                                               : i_state.target_y - i_pos_y;
    assign w_arrived = (w_dx < i_tolerance) && (w_dy < i_tolerance);
    assign w_even    = ~i_state.step[0];

    assign w_near = (i_state.kind == PAT_ZIG_V) ? i_state.bounds.min_x
                                                : i_state.bounds.min_y;
    assign w_far  = (i_state.kind == PAT_ZIG_V) ? i_state.bounds.max_x
                                                : i_state.bounds.max_y;
    assign w_prod    = {8'd0, i_state.step} * {9'd0, i_step_size};
    assign w_line    = {10'd0, w_near} + {1'b0, w_prod};
    assign w_past    = w_line > {10'd0, w_far};
    assign w_phase_n = i_state.phase + 4'd1;

    always_comb begin
        o_state     = i_state;
        o_event     = EV_NONE;
        o_area_done = 1'b0;
        case (i_mode)
            MODE_TICK: begin
                if (i_state.running && w_arrived) begin
                    case (i_state.kind)
                        PAT_RECT: begin
                            o_state.step = i_state.step + 9'd1;
                            case (i_state.step)
                                9'd0: begin
                                    o_state.target_x = i_state.bounds.max_x;
                                    o_state.target_y = i_state.bounds.min_y;
                                end
                                9'd1: begin
                                    o_state.target_x = i_state.bounds.max_x;
                                    o_state.target_y = i_state.bounds.max_y;
                                end
                                9'd2: begin
                                    o_state.target_x = i_state.bounds.min_x;
                                    o_state.target_y = i_state.bounds.max_y;
                                end
                                9'd3: begin
                                    o_state.target_x = i_state.bounds.min_x;
                                    o_state.target_y = i_state.bounds.min_y;
                                end
                                default: begin
                                    o_state.step    = i_state.step;
                                    o_state.running = 1'b0;
                                    o_event         = EV_PREVIEW;
                                end
                            endcase
                        end
                        PAT_ZIG_H, PAT_ZIG_V: begin
                            if (w_past) begin
                                o_area_done   = 1'b1;
                                o_state.phase = w_phase_n;
                                if (w_phase_n < i_total_areas) begin
                                    o_state.bounds   = i_next_bounds;
                                    o_state.step     = 9'd0;
                                    o_state.running  = 1'b1;
                                    o_state.target_x = i_next_bounds.min_x;
                                    o_state.target_y = i_next_bounds.min_y;
                                end else begin
                                    o_state.running  = 1'b0;
                                    o_state.target_x = i_state.bounds.min_x;
                                    o_state.target_y = i_state.bounds.min_y;
                                    o_event          = EV_ATTACK;
                                end
                            end else begin
                                o_state.step = i_state.step + 9'd1;
                                if (i_state.kind == PAT_ZIG_H) begin
                                    o_state.target_x = w_even ? i_state.bounds.max_x
                                                              : i_state.bounds.min_x;
                                    o_state.target_y = w_line[7:0];
                                end else begin
                                    o_state.target_x = w_line[7:0];
                                    o_state.target_y = w_even ? i_state.bounds.max_y
                                                              : i_state.bounds.min_y;
                                end
                            end
                        end
                        default: begin
                            o_state.running = 1'b0;
                            o_event         = EV_UNKNOWN;
                        end
                    endcase
                end
            end
            MODE_START: begin
                o_state.kind     = i_pattern;
                o_state.bounds   = i_bounds;
                o_state.step     = 9'd0;
                o_state.running  = 1'b1;
                o_state.target_x = i_bounds.min_x;
                o_state.target_y = i_bounds.min_y;
                o_state.phase    = 4'd0;
            end
            MODE_STOP: begin
                o_state.running  = 1'b0;
                o_state.target_x = i_home_x;
                o_state.target_y = i_home_y;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule : ptsps_step
`default_nettype wire
